>>> design/bfm_pkg.sv
// Package for the bit map find-and-modify block.
// Holds operation and status codes and the fixed field widths.
// No dependencies.
`default_nettype none

package bfm_pkg;

	// fixed field widths of the transaction ports
	localparam int OP_W   = 4;
	localparam int IDX_W  = 8;
	localparam int STAT_W = 2;
	localparam int POS_W  = 8;
	localparam int CFG_W  = 9;

	// operation codes
	localparam logic [OP_W-1:0] OP_TEST            = 4'd0;
	localparam logic [OP_W-1:0] OP_SET             = 4'd1;
	localparam logic [OP_W-1:0] OP_CLEAR           = 4'd2;
	localparam logic [OP_W-1:0] OP_TOGGLE          = 4'd3;
	localparam logic [OP_W-1:0] OP_TEST_SET        = 4'd4;
	localparam logic [OP_W-1:0] OP_TEST_CLEAR      = 4'd5;
	localparam logic [OP_W-1:0] OP_LAST_SET_CLEAR  = 4'd6;
	localparam logic [OP_W-1:0] OP_LAST_ZERO_SET   = 4'd7;
	localparam logic [OP_W-1:0] OP_FIRST_SET_CLEAR = 4'd8;
	localparam logic [OP_W-1:0] OP_FIRST_ZERO_SET  = 4'd9;

	// result status codes
	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_REFUSED = 2'd1;
	localparam logic [STAT_W-1:0] ST_NONE    = 2'd2;

	// reset value of the scan range register
	localparam logic [CFG_W-1:0] BITS_IN_USE_RST = 9'd256;

	// what the head cell reports for the word under it
	typedef struct packed {
		logic bit_hit;   // addressed bit lies in this word
		logic bit_old;   // its value before the operation
		logic scan_hit;  // scan matched a bit in this word
	} head_flags_t;

endpackage

`default_nettype wire

>>> design/bfm_cell.sv
// One storage cell of the rotating word chain: holds one map word.
// Takes its neighbour's word on every shift cycle, in either direction.
// Depends on nothing.
`default_nettype none

module bfm_cell #(
	parameter int WORD_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 shift,
	input  wire logic                 dir_up,
	input  wire logic [WORD_BITS-1:0] from_hi,
	input  wire logic [WORD_BITS-1:0] from_lo,
	output logic      [WORD_BITS-1:0] word
);

	logic [WORD_BITS-1:0] word_q;

	// map is all zeros after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (shift) begin
			word_q <= dir_up ? from_hi : from_lo;
		end
	end

	assign word = word_q;

endmodule

`default_nettype wire

>>> design/bfm_head.sv
// Head logic of the word chain: examines the word leaving the chain,
// applies the single-bit or scan modification and reports what it saw.
// Depends on bfm_pkg.
`default_nettype none

module bfm_head
	import bfm_pkg::*;
#(
	parameter int WORD_BITS = 32,
	parameter int MAP_BITS  = 256,
	parameter int BW        = 9
) (
	input  wire logic [WORD_BITS-1:0]         word_i,
	input  wire logic [BW-1:0]                base,
	input  wire logic [OP_W-1:0]              op,
	input  wire logic [IDX_W-1:0]             idx,
	input  wire logic [BW-1:0]                scan_n,
	input  wire logic                         found_before,
	output logic      [WORD_BITS-1:0]         word_o,
	output head_flags_t                       flags,
	output logic      [BW-1:0]                scan_pos
);

	localparam int OW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam logic [BW-1:0] WB_B  = BW'(WORD_BITS);
	localparam logic [BW-1:0] MAP_B = BW'(MAP_BITS);

	logic [BW-1:0]        idx_w;
	logic [BW-1:0]        idx_off;
	logic [OW-1:0]        off;
	logic                 old;
	logic                 bit_hit;
	logic                 scan_hit;
	logic                 is_scan;
	logic                 want;
	logic                 up;
	logic [BW-1:0]        rem;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] cand;
	logic [OW-1:0]        lo_off;
	logic [OW-1:0]        hi_off;
	logic [OW-1:0]        hit_off;
	logic                 any;

	// addressed bit within this word
	always_comb begin
		idx_w   = BW'(idx);
		idx_off = idx_w - base;
		off     = idx_off[OW-1:0];
		bit_hit = (idx_w >= base) && (idx_w < base + WB_B) && (idx_w < MAP_B);
		old     = word_i[off];
	end

	// scan candidates limited to the scan range
	always_comb begin
		is_scan = (op == OP_LAST_SET_CLEAR) || (op == OP_LAST_ZERO_SET) ||
		          (op == OP_FIRST_SET_CLEAR) || (op == OP_FIRST_ZERO_SET);
		want    = (op == OP_LAST_SET_CLEAR) || (op == OP_FIRST_SET_CLEAR);
		up      = (op == OP_FIRST_SET_CLEAR) || (op == OP_FIRST_ZERO_SET);
		rem     = (scan_n > base) ? (scan_n - base) : '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			mask[b] = (BW'(b) < rem);
		end
		cand = (want ? word_i : ~word_i) & mask;
		any  = |cand;
	end

	// lowest and highest candidate in the word
	always_comb begin
		lo_off = '0;
		hi_off = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (cand[b]) lo_off = OW'(b);
		end
		for (int b = 0; b < WORD_BITS; b++) begin
			if (cand[b]) hi_off = OW'(b);
		end
		hit_off  = up ? lo_off : hi_off;
		scan_hit = is_scan & ~found_before & any;
		scan_pos = base + BW'(hit_off);
	end

	// flags reported to the sequencer
	assign flags = '{bit_hit: bit_hit, bit_old: bit_hit & old, scan_hit: scan_hit};

	// word written back into the chain
	always_comb begin
		word_o = word_i;
		if (bit_hit) begin
			case (op)
				OP_SET:        word_o[off] = 1'b1;
				OP_CLEAR:      word_o[off] = 1'b0;
				OP_TOGGLE:     word_o[off] = ~old;
				OP_TEST_SET:   word_o[off] = 1'b1;
				OP_TEST_CLEAR: word_o[off] = 1'b0;
				default:       word_o[off] = old;
			endcase
		end
		if (scan_hit) begin
			word_o[hit_off] = ~want;
		end
	end

endmodule

`default_nettype wire

>>> design/bitmap_find_and_modify.sv
// Bit map find-and-modify top level: a rotating chain of word cells and
// its control. Depends on bfm_pkg, bfm_cell and bfm_head.
//
// An operation is taken when start is high and busy is low. The map words
// sit in a ring of cells; every operation rotates the whole ring once, one
// word per cycle past the head logic, which applies the change to the word
// it sees. busy is low again in the cycle that done is high, so the next
// start may be taken there. done is high for a single cycle and cannot be
// held off; status, bit_value and position hold until the next done. The
// user writes bits_in_use through cfg_we / cfg_wdata only while idle; the
// block itself does not enforce this.
`default_nettype none

module bitmap_find_and_modify
	import bfm_pkg::*;
#(
	parameter int MAP_BITS  = 256,
	parameter int WORD_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [OP_W-1:0]   operation,
	input  wire logic [IDX_W-1:0]  bit_index,
	input  wire logic              cfg_we,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	output logic                   done,
	output logic      [STAT_W-1:0] status,
	output logic                   bit_value,
	output logic      [POS_W-1:0]  position
);

	localparam int WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int PW    = $clog2(WORDS * WORD_BITS + 1);
	localparam int BW    = (PW > CFG_W) ? PW : CFG_W;
	localparam int CW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [BW-1:0] WB_B      = BW'(WORD_BITS);
	localparam logic [BW-1:0] MAP_B     = BW'(MAP_BITS);
	localparam logic [BW-1:0] TOP_BASE  = BW'((WORDS - 1) * WORD_BITS);
	localparam logic [CW-1:0] LAST_STEP = CW'(WORDS - 1);

	typedef enum logic {IDLE, RUN} state_t;

	state_t               state_q;
	logic [CW-1:0]        step_q;
	logic [BW-1:0]        base_q;
	logic [OP_W-1:0]      op_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 up_q;
	logic                 old_q;
	logic                 found_q;
	logic [BW-1:0]        fpos_q;
	logic [CFG_W-1:0]     bits_in_q;
	logic                 done_q;
	logic [STAT_W-1:0]    status_q;
	logic                 bit_value_q;
	logic [POS_W-1:0]     position_q;

	logic [WORD_BITS-1:0] cell_word [WORDS];
	logic [WORD_BITS-1:0] head_in;
	logic [WORD_BITS-1:0] head_out;
	logic [BW-1:0]        scan_n;
	logic [BW-1:0]        scan_pos;
	head_flags_t          flags;
	logic                 shift;
	logic                 nx_old;
	logic                 nx_found;
	logic [BW-1:0]        nx_fpos;
	logic                 is_scan;
	logic                 want;
	logic                 up_op;
	logic [STAT_W-1:0]    res_status;
	logic                 res_value;
	logic [POS_W-1:0]     res_pos;

	// scan range register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_in_q <= BITS_IN_USE_RST;
		end else if (cfg_we) begin
			bits_in_q <= cfg_wdata;
		end
	end

	assign scan_n = (BW'(bits_in_q) > MAP_B) ? MAP_B : BW'(bits_in_q);
	assign shift  = (state_q == RUN);

	// ring of word cells
	for (genvar i = 0; i < WORDS; i++) begin : g_cell
		logic [WORD_BITS-1:0] hi_w;
		logic [WORD_BITS-1:0] lo_w;
		if (i == WORDS - 1) begin : g_hi_wrap
			assign hi_w = head_out;
		end else begin : g_hi
			assign hi_w = cell_word[i+1];
		end
		if (i == 0) begin : g_lo_wrap
			assign lo_w = head_out;
		end else begin : g_lo
			assign lo_w = cell_word[i-1];
		end
		bfm_cell #(.WORD_BITS(WORD_BITS)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.dir_up  (up_q),
			.from_hi (hi_w),
			.from_lo (lo_w),
			.word    (cell_word[i])
		);
	end

	// head sees word 0 end when rotating up, the top end when rotating down
	assign head_in = up_q ? cell_word[0] : cell_word[WORDS-1];

	bfm_head #(
		.WORD_BITS (WORD_BITS),
		.MAP_BITS  (MAP_BITS),
		.BW        (BW)
	) u_head (
		.word_i       (head_in),
		.base         (base_q),
		.op           (op_q),
		.idx          (idx_q),
		.scan_n       (scan_n),
		.found_before (found_q),
		.word_o       (head_out),
		.flags        (flags),
		.scan_pos     (scan_pos)
	);

	// running results including the current step
	always_comb begin
		nx_old   = old_q | flags.bit_old;
		nx_found = found_q | flags.scan_hit;
		nx_fpos  = flags.scan_hit ? scan_pos : fpos_q;
		is_scan  = (op_q == OP_LAST_SET_CLEAR) || (op_q == OP_LAST_ZERO_SET) ||
		           (op_q == OP_FIRST_SET_CLEAR) || (op_q == OP_FIRST_ZERO_SET);
		want     = (op_q == OP_LAST_SET_CLEAR) || (op_q == OP_FIRST_SET_CLEAR);
		res_status = ST_DONE;
		res_value  = 1'b0;
		res_pos    = '0;
		case (op_q) inside
			OP_TEST, OP_SET, OP_CLEAR, OP_TOGGLE: begin
				res_value = nx_old;
			end
			OP_TEST_SET: begin
				res_value = nx_old;
				if (nx_old) res_status = ST_REFUSED;
			end
			OP_TEST_CLEAR: begin
				res_value = nx_old;
				if (!nx_old) res_status = ST_REFUSED;
			end
			default: begin
				if (is_scan) begin
					if (nx_found) begin
						res_value = want;
						res_pos   = nx_fpos[POS_W-1:0];
					end else begin
						res_status = ST_NONE;
					end
				end
			end
		endcase
	end

	// scans for the lowest bit rotate up, for the highest bit down
	assign up_op = !((operation == OP_LAST_SET_CLEAR) || (operation == OP_LAST_ZERO_SET));

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			done_q      <= 1'b0;
			up_q        <= 1'b1;
			step_q      <= '0;
			base_q      <= '0;
			op_q        <= OP_TEST;
			idx_q       <= '0;
			old_q       <= 1'b0;
			found_q     <= 1'b0;
			fpos_q      <= '0;
			status_q    <= ST_DONE;
			bit_value_q <= 1'b0;
			position_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= RUN;
						op_q    <= operation;
						idx_q   <= bit_index;
						up_q    <= up_op;
						base_q  <= up_op ? '0 : TOP_BASE;
						step_q  <= '0;
						old_q   <= 1'b0;
						found_q <= 1'b0;
						fpos_q  <= '0;
					end
				end
				RUN: begin
					old_q   <= nx_old;
					found_q <= nx_found;
					fpos_q  <= nx_fpos;
					step_q  <= step_q + 1'b1;
					base_q  <= up_q ? (base_q + WB_B) : (base_q - WB_B);
					if (step_q == LAST_STEP) begin
						state_q     <= IDLE;
						done_q      <= 1'b1;
						status_q    <= res_status;
						bit_value_q <= res_value;
						position_q  <= res_pos;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign busy      = (state_q == RUN);
	assign done      = done_q;
	assign status    = status_q;
	assign bit_value = bit_value_q;
	assign position  = position_q;

endmodule

`default_nettype wire

>>> design/bfm_checker.sv
// Port-level checker for bitmap_find_and_modify, bound to the top level.
// Depends on bfm_pkg.
`default_nettype none

module bfm_checker
	import bfm_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic [STAT_W-1:0] status,
	input wire logic              bit_value,
	input wire logic [POS_W-1:0]  position
);

	// an accepted transaction keeps the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an accepted transaction");

	// a result only appears once the block has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("done without a transaction in progress");

	// never two results in consecutive cycles
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// status code in range, and an empty scan reports zeros
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((status == ST_DONE) || (status == ST_REFUSED) ||
		          ((status == ST_NONE) && (position == '0) && !bit_value)))
		else $error("bad status or non-zero fields on an empty scan");

endmodule

bind bitmap_find_and_modify bfm_checker u_bfm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.bit_value (bit_value),
	.position  (position)
);

`default_nettype wire

>>> sim/testbench.sv
// Testbench for the bit map find-and-modify block: directed table then random phases.
// Depends on bfm_pkg and bitmap_find_and_modify; results match a local map model or a typed row.
`timescale 1ns / 1ps

module testbench;
	import bfm_pkg::*;

	localparam int MAP_SIZE  = 256;
	localparam int WORD_SIZE = 32;

	// operation codes with no function
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd10;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;

	localparam int NUM_DIRECTED  = 31;
	localparam int NUM_PHASES    = 10;
	localparam int PHASE_ITEMS   = 115;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              bit_value;
		logic [POS_W-1:0]  position;
	} map_result_t;

	typedef enum logic {ROW_OP, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {MIX_UNIFORM, MIX_FILL, MIX_DRAIN} op_mix_t;

	// one directed row: an operation (result typed in when fixed) or a range write
	typedef struct packed {
		row_kind_t         kind;
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  idx;
		logic [CFG_W-1:0]  cfg_value;
		logic              fixed;
		logic [STAT_W-1:0] status;
		logic              bit_value;
		logic [POS_W-1:0]  position;
	} stim_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic [OP_W-1:0]   operation = '0;
	logic [IDX_W-1:0]  bit_index = '0;
	logic              cfg_we    = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              busy;
	logic              done;
	logic [STAT_W-1:0] status;
	logic              bit_value;
	logic [POS_W-1:0]  position;

	// model state
	logic [MAP_SIZE-1:0] model_map  = '0;
	logic [CFG_W-1:0]    scan_range = BITS_IN_USE_RST;

	map_result_t expected_results[$];
	int mismatches   = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int scans_empty  = 0;
	int range_writes = 0;
	bit idling_on    = 1'b1;

	stim_row_t directed_rows [NUM_DIRECTED] = '{
		'{ROW_OP,  OP_TEST,            8'd0,   9'd0,   1'b1, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_FIRST_SET_CLEAR, 8'd0,   9'd0,   1'b1, ST_NONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_LAST_SET_CLEAR,  8'd255, 9'd0,   1'b1, ST_NONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_TEST_CLEAR,      8'd255, 9'd0,   1'b1, ST_REFUSED, 1'b0, 8'd0},
		'{ROW_OP,  OP_TEST_SET,        8'd255, 9'd0,   1'b1, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_TEST_SET,        8'd255, 9'd0,   1'b1, ST_REFUSED, 1'b1, 8'd0},
		'{ROW_OP,  OP_SET,             8'd0,   9'd0,   1'b1, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_FIRST_SET_CLEAR, 8'd0,   9'd0,   1'b1, ST_DONE,    1'b1, 8'd0},
		'{ROW_OP,  OP_FIRST_ZERO_SET,  8'd0,   9'd0,   1'b1, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_LAST_ZERO_SET,   8'd0,   9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_LAST_SET_CLEAR,  8'd0,   9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_TOGGLE,          8'd128, 9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_TOGGLE,          8'd128, 9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_CLEAR,           8'd0,   9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_TEST_CLEAR,      8'd254, 9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_SET,             8'd31,  9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_SET,             8'd32,  9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_TEST,            8'd31,  9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_SPARE_FIRST,     8'd77,  9'd0,   1'b1, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_SPARE_LAST,      8'd255, 9'd0,   1'b1, ST_DONE,    1'b0, 8'd0},
		'{ROW_CFG, OP_TEST,            8'd0,   9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_FIRST_ZERO_SET,  8'd0,   9'd0,   1'b1, ST_NONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_LAST_SET_CLEAR,  8'd0,   9'd0,   1'b1, ST_NONE,    1'b0, 8'd0},
		'{ROW_CFG, OP_TEST,            8'd0,   9'd1,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_FIRST_ZERO_SET,  8'd0,   9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_FIRST_ZERO_SET,  8'd0,   9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_LAST_SET_CLEAR,  8'd0,   9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_CFG, OP_TEST,            8'd0,   9'd511, 1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_LAST_SET_CLEAR,  8'd0,   9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_OP,  OP_FIRST_ZERO_SET,  8'd0,   9'd0,   1'b0, ST_DONE,    1'b0, 8'd0},
		'{ROW_CFG, OP_TEST,            8'd0,   9'd256, 1'b0, ST_DONE,    1'b0, 8'd0}
	};

	bitmap_find_and_modify #(
		.MAP_BITS  (MAP_SIZE),
		.WORD_BITS (WORD_SIZE)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.bit_index (bit_index),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.status    (status),
		.bit_value (bit_value),
		.position  (position)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 50) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	// apply one operation to the model map and return what the block should answer
	function automatic map_result_t bitmap_apply(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] idx);
		map_result_t res;
		logic        old;
		logic        want;
		logic        found;
		int          span;
		int          p;
		int          hit;
		res    = '0;
		old    = model_map[idx];
		found  = 1'b0;
		hit    = 0;
		case (op) inside
			OP_TEST: begin
				res.bit_value = old;
			end
			OP_SET: begin
				res.bit_value  = old;
				model_map[idx] = 1'b1;
			end
			OP_CLEAR: begin
				res.bit_value  = old;
				model_map[idx] = 1'b0;
			end
			OP_TOGGLE: begin
				res.bit_value  = old;
				model_map[idx] = ~old;
			end
			OP_TEST_SET: begin
				res.bit_value = old;
				if (old) res.status = ST_REFUSED;
				else model_map[idx] = 1'b1;
			end
			OP_TEST_CLEAR: begin
				res.bit_value = old;
				if (!old) res.status = ST_REFUSED;
				else model_map[idx] = 1'b0;
			end
			OP_LAST_SET_CLEAR, OP_LAST_ZERO_SET, OP_FIRST_SET_CLEAR, OP_FIRST_ZERO_SET: begin
				want = (op == OP_LAST_SET_CLEAR || op == OP_FIRST_SET_CLEAR);
				span = (int'(scan_range) > MAP_SIZE) ? MAP_SIZE : int'(scan_range);
				// walk up from bit 0 or down from the top of the range
				for (int k = 0; k < span && !found; k++) begin
					p = (op == OP_FIRST_SET_CLEAR || op == OP_FIRST_ZERO_SET) ? k : span - 1 - k;
					if (model_map[p] == want) begin
						found = 1'b1;
						hit   = p;
					end
				end
				if (found) begin
					res.bit_value  = want;
					res.position   = hit[POS_W-1:0];
					model_map[hit] = ~want;
				end else begin
					res.status = ST_NONE;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// drive one transaction, wait for it to be taken, then maybe idle for a burst
	task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic fixed, input map_result_t fixed_res);
		map_result_t predicted;
		start     <= 1'b1;
		operation <= op;
		bit_index <= idx;
		do @(posedge clk); while (busy);
		predicted = bitmap_apply(op, idx);
		expected_results.push_back(fixed ? fixed_res : predicted);
		items_sent++;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// range register is only written with the block idle and nothing outstanding
	task automatic write_scan_range(input logic [CFG_W-1:0] value);
		start <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0 || busy);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		scan_range  = value;
		range_writes++;
	endtask

	// result checker: one transaction per done strobe
	always @(posedge clk) begin
		map_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (status == ST_NONE) scans_empty++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no operation outstanding");
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				if (bit_value !== want.bit_value)
					report_mismatch($sformatf("bit_value %0d, expected %0d", bit_value,
						want.bit_value));
				if (position !== want.position)
					report_mismatch($sformatf("position %0d, expected %0d", position,
						want.position));
			end
		end
	end

	// main stimulus
	initial begin
		stim_row_t        row;
		map_result_t      typed;
		op_mix_t          mix;
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		logic [CFG_W-1:0] range_value;
		int               lim;
		int               pick;
		int               waited;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			row = directed_rows[i];
			if (row.kind == ROW_CFG) begin
				write_scan_range(row.cfg_value);
			end else begin
				typed = {row.status, row.bit_value, row.position};
				send_op(row.op, row.idx, row.fixed, typed);
			end
		end

		// random phases, each under its own scan range and operation mix
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: range_value = 9'd1;
				1: range_value = 9'd511;
				2: range_value = 9'd0;
				3: range_value = 9'd256;
				default: begin
					case ($urandom_range(0, 3))
						0: range_value = 9'($urandom_range(2, 40));
						1: range_value = 9'($urandom_range(41, 255));
						2: range_value = 9'($urandom_range(257, 511));
						default: range_value = 9'd32 << $urandom_range(0, 3);
					endcase
				end
			endcase
			write_scan_range(range_value);
			mix       = op_mix_t'($urandom_range(0, 2));
			idling_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// operation: rare spare codes, otherwise biased by the phase mix
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					op = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
				end else if (pick < 64 && mix == MIX_FILL) begin
					case ($urandom_range(0, 3))
						0: op = OP_FIRST_ZERO_SET;
						1: op = OP_LAST_ZERO_SET;
						2: op = OP_SET;
						default: op = OP_TEST_SET;
					endcase
				end else if (pick < 64 && mix == MIX_DRAIN) begin
					case ($urandom_range(0, 3))
						0: op = OP_FIRST_SET_CLEAR;
						1: op = OP_LAST_SET_CLEAR;
						2: op = OP_CLEAR;
						default: op = OP_TEST_CLEAR;
					endcase
				end else begin
					op = 4'($urandom_range(OP_TEST, OP_FIRST_ZERO_SET));
				end

				// index: often inside the scan range so scans see the changes
				lim  = (int'(scan_range) > MAP_SIZE) ? MAP_SIZE : int'(scan_range);
				pick = $urandom_range(0, 9);
				if (pick == 0) idx = '0;
				else if (pick == 1) idx = '1;
				else if (pick < 6 && lim > 0) idx = 8'($urandom_range(0, lim - 1));
				else idx = 8'($urandom_range(0, MAP_SIZE - 1));

				send_op(op, idx, 1'b0, '0);
			end
		end

		// drain, then keep the clock running so any stray result can show
		start  <= 1'b0;
		waited  = 0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_results.size() != 0)
			report_mismatch("timed out waiting for outstanding results");
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		$display("Ran %0d transactions across %0d scan range writes; %0d results checked.",
			items_sent, range_writes, results_seen);
		$display("%0d results reported no bit found; %0d mismatches.", scans_empty, mismatches);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
